>>> rtl/core/ihex_pkg.sv
// Shared types, codes and helpers of the Intel HEX record parser.
// Depends on nothing; used by intel_hex_record_parser.
`default_nettype none

package ihex_pkg;

  // Parser phase within a line (plain 3-bit state vector)
  localparam logic [2:0] PH_WAIT   = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_OFFSET = 3'd2;
  localparam logic [2:0] PH_TYPE   = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_CKSUM  = 3'd5;
  localparam logic [2:0] PH_TRAIL  = 3'd6;

  // Result kinds
  localparam logic [1:0] K_BYTE  = 2'd0;
  localparam logic [1:0] K_REC   = 2'd1;
  localparam logic [1:0] K_FINAL = 2'd2;

  // Status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_EOF_REC   = 4'd1;
  localparam logic [3:0] ST_SHORT     = 4'd2;
  localparam logic [3:0] ST_NO_COLON  = 4'd3;
  localparam logic [3:0] ST_LENGTH    = 4'd4;
  localparam logic [3:0] ST_CKSUM     = 4'd5;
  localparam logic [3:0] ST_DATA_GAP  = 4'd6;
  localparam logic [3:0] ST_SEG_GAP   = 4'd7;
  localparam logic [3:0] ST_LIN_GAP   = 4'd8;
  localparam logic [3:0] ST_TYPE03    = 4'd9;
  localparam logic [3:0] ST_UNKNOWN   = 4'd10;
  localparam logic [3:0] ST_NO_EOF    = 4'd11;
  localparam logic [3:0] ST_BAD_DIGIT = 4'd12;

  // Record types
  localparam logic [7:0] RT_DATA    = 8'h00;
  localparam logic [7:0] RT_EOF     = 8'h01;
  localparam logic [7:0] RT_SEG     = 8'h02;
  localparam logic [7:0] RT_SEG_ST  = 8'h03;
  localparam logic [7:0] RT_LIN     = 8'h04;
  localparam logic [7:0] RT_LIN_ST  = 8'h05;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Output queue depth
  localparam int unsigned OutDepth = 4;

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] address;
    logic [3:0]  status;
    logic [31:0] line_number;
    logic [31:0] start_address;
    logic [31:0] image_base;
    logic [31:0] image_length;
    logic        last;
  } res_t;

  // Decode one hex digit; bit 4 set means the character is not a hex digit.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    case (c) inside
      [8'h30:8'h39]:               r = {1'b0, c[3:0]};
      [8'h41:8'h46], [8'h61:8'h66]: r = {1'b0, c[3:0] + 4'd9};
      default:                     r = 5'h10;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/intel_hex_record_parser.sv
// Intel HEX record parser: character stream in, data bytes and statuses out.
// Depends on ihex_pkg.
`default_nettype none

// Usage:
// The slave channel takes one text character per transaction in tdata; tlast
// high marks end of stream, which closes a partial line and reports the final
// status (tdata is then ignored). Each accepted character is parsed in the
// cycle it is accepted and gives zero, one or two result transactions on the
// master channel: tuser holds the kind (data byte, record status, final
// status), tdata the byte, its address, the status, line number, start
// address, image base and image length; tlast marks the last result of the
// character. A data byte is tentative until the record status that follows
// it reads zero.
// Results are registered into the output queue on acceptance. Throughput is
// one character per cycle while tready is high; an end of stream that closes
// a partial line yields two results.
// Results go through a four-entry output queue; tready on the slave side is
// high while at most two entries are held, so a stalled receiver backs up
// into the input once more than two entries are held, and nothing is lost.
// Reset clears the parser to wait for a start code with status "no eof".
module intel_hex_record_parser
  import ihex_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [7:0]   s_axis_tdata_i,   // [7:0] character
  input  wire logic         s_axis_tlast_i,   // end_of_file
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // [7:0] data_byte, [39:8] address, [43:40] status, [75:44] line_number,
  // [107:76] start_address, [139:108] image_base, [171:140] image_length,
  // [175:172] zero
  output logic [175:0]      m_axis_tdata_o,
  output logic [1:0]        m_axis_tuser_o,   // [1:0] kind
  output logic              m_axis_tlast_o    // last
);

  localparam int unsigned PtrW = $clog2(OutDepth);
  localparam int unsigned CntW = $clog2(OutDepth + 1);

  // Parser state
  logic [2:0]  phase_q, phase_d;
  logic [8:0]  nib_q, nib_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] off_q, off_d;
  logic [7:0]  rtype_q, rtype_d;
  logic [7:0]  csum_q, csum_d;
  logic [7:0]  asm_q, asm_d;
  logic [31:0] payload_q, payload_d;
  logic [31:0] base_q, base_d;
  logic [31:0] count_q, count_d;
  logic [31:0] start_q, start_d;
  logic [31:0] line_q, line_d;
  logic [3:0]  sticky_q, sticky_d;
  logic        stopped_q, stopped_d;

  // Output queue
  res_t            fifo_q [OutDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  logic       in_acc, out_pop;
  res_t       r0, r1;
  logic [1:0] n_push;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_pop = m_axis_tvalid_o && m_axis_tready_i;

  // Per-character parse step
  always_comb begin
    logic [4:0]  hv;
    logic [7:0]  b;
    logic [8:0]  nib_new;
    logic [7:0]  idx;
    logic [31:0] sum_bc;
    logic [31:0] nb;
    logic [3:0]  code;
    logic [3:0]  st;
    logic [7:0]  csum_new;

    phase_d   = phase_q;
    nib_d     = nib_q;
    len_d     = len_q;
    off_d     = off_q;
    rtype_d   = rtype_q;
    csum_d    = csum_q;
    asm_d     = asm_q;
    payload_d = payload_q;
    base_d    = base_q;
    count_d   = count_q;
    start_d   = start_q;
    line_d    = line_q;
    sticky_d  = sticky_q;
    stopped_d = stopped_q;
    r0        = '0;
    r1        = '0;
    n_push    = 2'd0;

    hv       = hex_decode(s_axis_tdata_i);
    b        = {asm_q[3:0], hv[3:0]};
    nib_new  = nib_q + 9'd1;
    idx      = nib_new[8:1] - 8'd1;
    sum_bc   = base_q + count_q;
    nb       = '0;
    code     = ST_OK;
    st       = ST_OK;
    csum_new = csum_q + b;

    if (in_acc) begin
      if (s_axis_tlast_i) begin
        // End of stream: close a partial line, then the final status
        if (!stopped_q && phase_q != PH_WAIT && phase_q != PH_TRAIL) begin
          code      = (phase_q <= PH_TYPE) ? ST_SHORT : ST_LENGTH;
          sticky_d  = code;
          r0.kind   = K_REC;
          r0.status = code;
          r1.kind   = K_FINAL;
          r1.status = code;
          n_push    = 2'd2;
        end else begin
          r0.kind   = K_FINAL;
          r0.status = sticky_q;
          n_push    = 2'd1;
        end
        stopped_d = 1'b1;
        phase_d   = PH_WAIT;
      end else if (!stopped_q && s_axis_tdata_i != CH_CR) begin
        if (phase_q == PH_WAIT) begin
          // Start of a line
          line_d = line_q + 32'd1;
          if (s_axis_tdata_i == CH_COLON) begin
            phase_d   = PH_LEN;
            nib_d     = '0;
            len_d     = '0;
            off_d     = '0;
            rtype_d   = '0;
            csum_d    = '0;
            asm_d     = '0;
            payload_d = '0;
          end else begin
            code = (s_axis_tdata_i == CH_LF) ? ST_SHORT : ST_NO_COLON;
          end
        end else if (phase_q == PH_TRAIL) begin
          if (s_axis_tdata_i == CH_LF) begin
            phase_d = PH_WAIT;
          end
        end else if (s_axis_tdata_i == CH_LF) begin
          code = (phase_q <= PH_TYPE) ? ST_SHORT : ST_LENGTH;
        end else if (hv[4]) begin
          code = ST_BAD_DIGIT;
        end else begin
          // A hex digit; every second one completes a byte
          asm_d = b;
          nib_d = nib_new;
          if (!nib_new[0]) begin
            csum_d = csum_new;
            case (phase_q)
              PH_LEN: begin
                len_d   = b;
                phase_d = PH_OFFSET;
                nib_d   = '0;
              end
              PH_OFFSET: begin
                off_d = {off_q[7:0], b};
                if (nib_new >= 9'd4) begin
                  phase_d = PH_TYPE;
                  nib_d   = '0;
                end
              end
              PH_TYPE: begin
                rtype_d = b;
                phase_d = (len_q != 8'd0) ? PH_DATA : PH_CKSUM;
                nib_d   = '0;
              end
              PH_DATA: begin
                // The first four payload bytes fill the word from the top
                if (idx < 8'd4) begin
                  case (idx[1:0])
                    2'd0:    payload_d[31:24] = payload_q[31:24] | b;
                    2'd1:    payload_d[23:16] = payload_q[23:16] | b;
                    2'd2:    payload_d[15:8]  = payload_q[15:8] | b;
                    default: payload_d[7:0]   = payload_q[7:0] | b;
                  endcase
                end
                if (rtype_q == RT_DATA) begin
                  r0.kind      = K_BYTE;
                  r0.data_byte = b;
                  r0.address   = base_q + ((count_q == 32'd0) ? {16'd0, off_q} : count_q)
                                 + {24'd0, idx};
                  n_push       = 2'd1;
                end
                if (nib_new >= {len_q, 1'b0}) begin
                  phase_d = PH_CKSUM;
                  nib_d   = '0;
                end
              end
              default: begin
                // Checksum byte: close the record
                if (csum_new != 8'd0) begin
                  st = ST_CKSUM;
                end else begin
                  case (rtype_q)
                    RT_DATA: begin
                      if (count_q == 32'd0) begin
                        base_d = base_q + {16'd0, off_q};
                      end else if (sum_bc[15:0] != off_q) begin
                        st = ST_DATA_GAP;
                      end
                      if (st == ST_OK) begin
                        count_d = count_q + {24'd0, len_q};
                      end
                    end
                    RT_EOF: st = ST_EOF_REC;
                    RT_SEG: begin
                      nb = {12'd0, payload_q[31:16], 4'd0};
                      if (count_q != 32'd0) begin
                        if (nb != sum_bc) st = ST_SEG_GAP;
                      end else begin
                        base_d = {nb[31:4], base_q[3:0]};
                      end
                    end
                    RT_SEG_ST: st = ST_TYPE03;
                    RT_LIN: begin
                      nb = {payload_q[31:16], 16'd0};
                      if (count_q != 32'd0) begin
                        if (nb != sum_bc) st = ST_LIN_GAP;
                      end else begin
                        base_d = {nb[31:16], base_q[15:0]};
                      end
                    end
                    RT_LIN_ST: start_d = payload_q;
                    default:   st = ST_UNKNOWN;
                  endcase
                end
                nib_d = '0;
                if (st != ST_OK) begin
                  sticky_d  = st;
                  stopped_d = 1'b1;
                  phase_d   = PH_WAIT;
                end else begin
                  phase_d = PH_TRAIL;
                end
                r0.kind   = K_REC;
                r0.status = st;
                n_push    = 2'd1;
              end
            endcase
          end
        end

        // Line-level error: stop with a record status
        if (code != ST_OK) begin
          sticky_d  = code;
          stopped_d = 1'b1;
          phase_d   = PH_WAIT;
          r0.kind   = K_REC;
          r0.status = code;
          n_push    = 2'd1;
        end
      end
    end

    // Every result carries the updated image registers
    r0.line_number   = line_d;
    r0.start_address = start_d;
    r0.image_base    = base_d;
    r0.image_length  = count_d;
    r1.line_number   = line_d;
    r1.start_address = start_d;
    r1.image_base    = base_d;
    r1.image_length  = count_d;
    r0.last          = (n_push == 2'd1);
    r1.last          = 1'b1;
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT;
      nib_q     <= '0;
      len_q     <= '0;
      off_q     <= '0;
      rtype_q   <= '0;
      csum_q    <= '0;
      asm_q     <= '0;
      payload_q <= '0;
      base_q    <= '0;
      count_q   <= '0;
      start_q   <= '0;
      line_q    <= '0;
      sticky_q  <= ST_NO_EOF;
      stopped_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      nib_q     <= nib_d;
      len_q     <= len_d;
      off_q     <= off_d;
      rtype_q   <= rtype_d;
      csum_q    <= csum_d;
      asm_q     <= asm_d;
      payload_q <= payload_d;
      base_q    <= base_d;
      count_q   <= count_d;
      start_q   <= start_d;
      line_q    <= line_d;
      sticky_q  <= sticky_d;
      stopped_q <= stopped_d;
    end
  end

  // Output queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(n_push);
      rd_q  <= rd_q + PtrW'(out_pop);
      cnt_q <= cnt_q + CntW'(n_push) - CntW'(out_pop);
    end
  end

  // Output queue entries
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_q] <= r0;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_q + PtrW'(1)] <= r1;
    end
  end

  // Room for a two-result transaction keeps the input open
  assign s_axis_tready_o = (cnt_q <= CntW'(OutDepth - 2));
  assign m_axis_tvalid_o = (cnt_q != '0);

  // Head of the queue onto the master channel
  always_comb begin
    res_t head;
    head            = fifo_q[rd_q];
    m_axis_tdata_o  = {4'd0, head.image_length, head.image_base, head.start_address,
                       head.line_number, head.status, head.address, head.data_byte};
    m_axis_tuser_o  = head.kind;
    m_axis_tlast_o  = head.last;
  end

endmodule

`default_nettype wire

>>> sim/tb_intel_hex_record_parser.sv
// Self-checking testbench of intel_hex_record_parser: HEX text in, checked results out.
// Depends on ihex_pkg and intel_hex_record_parser; carries its own parser model.
module tb_intel_hex_record_parser;
  import ihex_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Ways in which the stream is closed at the end of the run.
  typedef enum int {
    END_EOF_RECORD, END_AT_LINE_BREAK, END_MID_LINE, END_EMPTY_LINE, END_NO_COLON,
    END_SHORT_LINE, END_CUT_PAYLOAD, END_BAD_CHECKSUM, END_DATA_GAP, END_SEG_GAP,
    END_LIN_GAP, END_TYPE03, END_UNKNOWN_TYPE, END_BAD_DIGIT
  } stream_end_e;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i = 8'h00;   // [7:0] character
  logic         s_axis_tlast_i = 1'b0;    // end_of_file
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  // [7:0] data_byte, [39:8] address, [43:40] status, [75:44] line_number,
  // [107:76] start_address, [139:108] image_base, [171:140] image_length
  logic [175:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;           // [1:0] kind
  logic         m_axis_tlast_o;           // last

  intel_hex_record_parser uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  // Parser model state, starting from the reset values.
  logic [2:0]  ph        = PH_WAIT;
  logic [8:0]  nib_cnt   = '0;
  logic [7:0]  rec_len   = '0;
  logic [15:0] rec_off   = '0;
  logic [7:0]  rec_type  = '0;
  logic [7:0]  sum       = '0;
  logic [7:0]  asm_byte  = '0;
  logic [31:0] payload   = '0;
  logic [31:0] img_base  = '0;
  logic [31:0] img_count = '0;
  logic [31:0] start_reg = '0;
  logic [31:0] line_cnt  = '0;
  logic [3:0]  sticky    = ST_NO_EOF;
  logic        halted    = 1'b0;

  res_t awaited_results[$];   // results still to come out, oldest first
  res_t step_q[$];            // results of the character being parsed
  logic [7:0] payload_q[$];   // data bytes of the record being built
  logic [7:0] line_q[$];      // characters of the line being built

  int items_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  bit quiet_sides = 1'b0;
  stream_end_e end_case = END_AT_LINE_BREAK;

  // ---------------------------------------------------------------- model

  function automatic int digit_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  function automatic void add_result(logic [1:0] kind, logic [7:0] d, logic [31:0] a,
                                     logic [3:0] st);
    res_t r;
    r.kind          = kind;
    r.data_byte     = d;
    r.address       = a;
    r.status        = st;
    r.line_number   = line_cnt;
    r.start_address = start_reg;
    r.image_base    = img_base;
    r.image_length  = img_count;
    r.last          = 1'b0;
    step_q.push_back(r);
  endfunction

  // Any error stops the parser for good.
  function automatic void halt_with(logic [3:0] code);
    sticky = code;
    halted = 1'b1;
    ph = PH_WAIT;
    add_result(K_REC, 8'h00, 32'h0, code);
  endfunction

  // Checksum, address continuity and the effect of the record type.
  function automatic logic [3:0] close_record();
    logic [31:0] nb;
    if (sum != 8'h00) return ST_CKSUM;
    case (rec_type)
      RT_DATA: begin
        if (img_count == 0) img_base = img_base + rec_off;
        else if (((img_base + img_count) & 32'hFFFF) != {16'h0, rec_off}) return ST_DATA_GAP;
        img_count = img_count + rec_len;
        return ST_OK;
      end
      RT_EOF: return ST_EOF_REC;
      RT_SEG: begin
        nb = (payload >> 16) << 4;
        if (img_count != 0) begin
          if (nb != img_base + img_count) return ST_SEG_GAP;
        end else begin
          img_base = (img_base & 32'h0F) | nb;
        end
        return ST_OK;
      end
      RT_SEG_ST: return ST_TYPE03;
      RT_LIN: begin
        nb = (payload >> 16) << 16;
        if (img_count != 0) begin
          if (nb != img_base + img_count) return ST_LIN_GAP;
        end else begin
          img_base = (img_base & 32'hFFFF) | nb;
        end
        return ST_OK;
      end
      RT_LIN_ST: begin
        start_reg = payload;
        return ST_OK;
      end
      default: return ST_UNKNOWN;
    endcase
  endfunction

  // A full byte has been assembled: route it to the field of the current phase.
  function automatic void absorb_byte();
    logic [7:0]  b;
    logic [31:0] idx;
    logic [31:0] a;
    logic [3:0]  st;
    b = asm_byte;
    idx = {23'd0, nib_cnt} / 2 - 1;
    sum = sum + b;
    case (ph)
      PH_LEN: begin
        rec_len = b;
        ph = PH_OFFSET;
        nib_cnt = '0;
      end
      PH_OFFSET: begin
        rec_off = {rec_off[7:0], b};
        if (nib_cnt >= 9'd4) begin
          ph = PH_TYPE;
          nib_cnt = '0;
        end
      end
      PH_TYPE: begin
        rec_type = b;
        ph = (rec_len != 0) ? PH_DATA : PH_CKSUM;
        nib_cnt = '0;
      end
      PH_DATA: begin
        if (idx < 4) payload = payload | ({24'd0, b} << (24 - 8 * idx));
        if (rec_type == RT_DATA) begin
          a = (img_count == 0) ? img_base + rec_off + idx : img_base + img_count + idx;
          add_result(K_BYTE, b, a, ST_OK);
        end
        if ({23'd0, nib_cnt} >= 2 * rec_len) begin
          ph = PH_CKSUM;
          nib_cnt = '0;
        end
      end
      default: begin
        st = close_record();
        nib_cnt = '0;
        if (st != ST_OK) begin
          sticky = st;
          halted = 1'b1;
          ph = PH_WAIT;
        end else begin
          ph = PH_TRAIL;
        end
        add_result(K_REC, 8'h00, 32'h0, st);
      end
    endcase
  endfunction

  // Parses one accepted transaction and queues the results it must cause.
  function automatic void parse_char(logic [7:0] ch, logic eof);
    int v;
    step_q.delete();
    if (eof) begin
      if (!halted && ph != PH_WAIT && ph != PH_TRAIL)
        halt_with(ph <= PH_TYPE ? ST_SHORT : ST_LENGTH);
      halted = 1'b1;
      ph = PH_WAIT;
      add_result(K_FINAL, 8'h00, 32'h0, sticky);
    end else if (!halted && ch != CH_CR) begin
      if (ph == PH_WAIT) begin
        line_cnt = line_cnt + 1;
        if (ch == CH_COLON) begin
          ph = PH_LEN;
          nib_cnt = '0;
          rec_len = '0;
          rec_off = '0;
          rec_type = '0;
          sum = '0;
          asm_byte = '0;
          payload = '0;
        end else begin
          halt_with(ch == CH_LF ? ST_SHORT : ST_NO_COLON);
        end
      end else if (ph == PH_TRAIL) begin
        if (ch == CH_LF) ph = PH_WAIT;
      end else if (ch == CH_LF) begin
        halt_with(ph <= PH_TYPE ? ST_SHORT : ST_LENGTH);
      end else begin
        v = digit_value(ch);
        if (v < 0) begin
          halt_with(ST_BAD_DIGIT);
        end else begin
          asm_byte = {asm_byte[3:0], v[3:0]};
          nib_cnt = nib_cnt + 9'd1;
          if (!nib_cnt[0]) absorb_byte();
        end
      end
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) awaited_results.push_back(step_q[i]);
  endfunction

  function automatic logic [31:0] next_addr();
    return img_base + img_count;
  endfunction

  // ---------------------------------------------------------------- driving

  // Sends one character transaction, with random idle cycles ahead of it.
  task automatic send_item(input logic [7:0] ch, input logic eof);
    while (!quiet_sides && $urandom_range(99) < 35) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= 8'($urandom_range(255));
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= ch;
    s_axis_tlast_i <= eof;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    parse_char(ch, eof);
    items_sent++;
  endtask

  // The receiver stalls at random except in the quiet stretch.
  always @(posedge clk_i) begin
    m_axis_tready_i <= quiet_sides || ($urandom_range(99) >= 35);
  end

  // ---------------------------------------------------------------- record text

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 10) return 8'h30 + n;
    if ($urandom_range(1)) return 8'h61 + n - 8'd10;
    return 8'h41 + n - 8'd10;
  endfunction

  // Now and then a carriage return lands in front of a character.
  function automatic void add_char(logic [7:0] c);
    if ($urandom_range(19) == 0) line_q.push_back(CH_CR);
    line_q.push_back(c);
  endfunction

  function automatic void add_hex(logic [7:0] b);
    add_char(hex_char(b[7:4]));
    add_char(hex_char(b[3:0]));
  endfunction

  // Builds a record from payload_q; ck_err corrupts the checksum when nonzero.
  function automatic void build_record(logic [15:0] off, logic [7:0] rtype, logic [7:0] ck_err);
    logic [7:0] len;
    logic [7:0] total;
    logic [7:0] ck;
    len = 8'(payload_q.size());
    line_q.delete();
    add_char(CH_COLON);
    total = len + off[15:8] + off[7:0] + rtype;
    add_hex(len);
    add_hex(off[15:8]);
    add_hex(off[7:0]);
    add_hex(rtype);
    foreach (payload_q[i]) begin
      add_hex(payload_q[i]);
      total = total + payload_q[i];
    end
    ck = (8'h00 - total) ^ ck_err;
    add_hex(ck);
  endfunction

  // Junk after the checksum is ignored up to the line feed.
  function automatic void add_tail();
    repeat ($urandom_range(0, 3)) line_q.push_back(8'($urandom_range(32, 126)));
    if ($urandom_range(1)) line_q.push_back(CH_CR);
    line_q.push_back(CH_LF);
  endfunction

  function automatic void fill_payload(int n);
    int r;
    payload_q.delete();
    repeat (n) begin
      r = $urandom_range(9);
      payload_q.push_back(r == 0 ? 8'h00 : r == 1 ? 8'hFF : 8'($urandom_range(255)));
    end
  endfunction

  // A character that is neither CR, LF nor colon, and a hex digit only if allowed.
  function automatic logic [7:0] pick_stray_char(bit allow_hex);
    logic [7:0] c;
    do
      c = 8'($urandom_range(255));
    while (c == CH_CR || c == CH_LF || c == CH_COLON || (!allow_hex && digit_value(c) >= 0));
    return c;
  endfunction

  function automatic void cut_line(int keep);
    while (line_q.size() > keep) void'(line_q.pop_back());
  endfunction

  task automatic send_line();
    foreach (line_q[i]) send_item(line_q[i], 1'b0);
  endtask

  task automatic put_record(input logic [15:0] off, input logic [7:0] rtype);
    build_record(off, rtype, 8'h00);
    add_tail();
    send_line();
  endtask

  // ---------------------------------------------------------------- tests

  // Address and start records while no data is committed, with short and long payloads.
  task automatic test_address_records();
    payload_q = '{8'h12, 8'h34};
    put_record(16'h0000, RT_LIN);
    payload_q = '{8'hAB};
    put_record(16'hFFFF, RT_SEG);
    payload_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    put_record(16'h0000, RT_LIN_ST);
    payload_q = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06};
    put_record(16'h8000, RT_LIN_ST);
    payload_q.delete();
    put_record(16'h0000, RT_LIN_ST);
    payload_q = '{8'hFF, 8'hFF, 8'h55};
    put_record(16'h0000, RT_LIN);
    // An empty data record still moves the base by its offset.
    payload_q.delete();
    put_record(16'h0010, RT_DATA);
  endtask

  // Data that wraps the 32-bit address, then matching linear and segment records.
  task automatic test_data_records();
    logic [31:0] nxt;
    payload_q = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA};
    put_record(16'hFFF8 - img_base[15:0], RT_DATA);
    nxt = next_addr();
    payload_q = '{nxt[31:24], nxt[23:16]};
    put_record(16'h0000, RT_LIN);
    nxt = next_addr();
    if (nxt[31:20] == 0 && nxt[3:0] == 0) begin
      payload_q = '{nxt[19:12], nxt[11:4], 8'h99};
      put_record(16'h0000, RT_SEG);
    end
    nxt = next_addr();
    payload_q = '{8'h5A};
    put_record(nxt[15:0], RT_DATA);
  endtask

  // Mostly contiguous data, with start records and address records where they fit.
  task automatic test_random_records();
    int first_item;
    int n_rec;
    int pick;
    bit long_done;
    logic [31:0] nxt;
    first_item = items_sent;
    n_rec = 0;
    long_done = 1'b0;
    while (items_sent - first_item < 100 || !long_done) begin
      quiet_sides = (n_rec >= 1 && n_rec < 6);
      nxt = next_addr();
      pick = $urandom_range(99);
      if (!long_done && (pick < 4 || items_sent - first_item >= 50)) begin
        // One long record.
        fill_payload(48);
        put_record(nxt[15:0], RT_DATA);
        long_done = 1'b1;
      end else if (pick < 60) begin
        fill_payload($urandom_range(0, 16));
        put_record(nxt[15:0], RT_DATA);
      end else if (pick < 70) begin
        fill_payload($urandom_range(0, 6));
        put_record(16'($urandom_range(65535)), RT_LIN_ST);
      end else if (pick < 85) begin
        // Segment base where the image is aligned, else pad up to alignment.
        if (nxt[31:20] == 0 && nxt[3:0] == 0) begin
          fill_payload($urandom_range(0, 2));
          payload_q.push_front(nxt[11:4]);
          payload_q.push_front(nxt[19:12]);
          put_record(16'($urandom_range(65535)), RT_SEG);
        end else begin
          fill_payload(16 - int'(nxt[3:0]));
          put_record(nxt[15:0], RT_DATA);
        end
      end else if (nxt[15:0] == 0) begin
        fill_payload($urandom_range(0, 2));
        payload_q.push_front(nxt[23:16]);
        payload_q.push_front(nxt[31:24]);
        put_record(16'($urandom_range(65535)), RT_LIN);
      end else begin
        fill_payload($urandom_range(1, 4));
        put_record(nxt[15:0], RT_DATA);
      end
      n_rec++;
    end
    quiet_sides = 1'b0;
  endtask

  // Closes the stream in one randomly chosen way; most of them stop the parser.
  task automatic test_stream_end();
    logic [31:0] nxt;
    logic [15:0] val;
    int cut;
    nxt = next_addr();
    val = 16'($urandom_range(65535));
    end_case = stream_end_e'($urandom_range(int'(END_BAD_DIGIT)));
    case (end_case)
      END_EOF_RECORD: begin
        payload_q.delete();
        put_record(16'h0000, RT_EOF);
      end
      END_AT_LINE_BREAK: begin
        // The end of stream itself follows a complete line.
      end
      END_MID_LINE: begin
        fill_payload($urandom_range(1, 4));
        build_record(nxt[15:0], RT_DATA, 8'h00);
        cut_line($urandom_range(1, line_q.size() - 1));
        send_line();
      end
      END_EMPTY_LINE: send_item(CH_LF, 1'b0);
      END_NO_COLON: begin
        line_q.delete();
        line_q.push_back(pick_stray_char(1'b1));
        add_tail();
        send_line();
      end
      END_SHORT_LINE: begin
        fill_payload(2);
        build_record(nxt[15:0], RT_DATA, 8'h00);
        cut_line($urandom_range(1, 8));
        line_q.push_back(CH_LF);
        send_line();
      end
      END_CUT_PAYLOAD: begin
        fill_payload($urandom_range(1, 8));
        build_record(nxt[15:0], RT_DATA, 8'h00);
        cut = $urandom_range(10, line_q.size() - 1);
        cut_line(cut);
        line_q.push_back(CH_LF);
        send_line();
      end
      END_BAD_CHECKSUM: begin
        fill_payload($urandom_range(0, 6));
        build_record(nxt[15:0], RT_DATA, 8'($urandom_range(1, 255)));
        add_tail();
        send_line();
      end
      END_DATA_GAP: begin
        fill_payload($urandom_range(1, 4));
        put_record(nxt[15:0] + 16'($urandom_range(1, 65535)), RT_DATA);
      end
      END_SEG_GAP: begin
        if ({12'd0, val, 4'd0} == nxt) val = val ^ 16'h0001;
        payload_q = '{val[15:8], val[7:0]};
        put_record(16'h0000, RT_SEG);
      end
      END_LIN_GAP: begin
        if ({val, 16'd0} == nxt) val = val ^ 16'h0001;
        payload_q = '{val[15:8], val[7:0]};
        put_record(16'h0000, RT_LIN);
      end
      END_TYPE03: begin
        fill_payload(4);
        put_record(16'h0000, RT_SEG_ST);
      end
      END_UNKNOWN_TYPE: begin
        fill_payload($urandom_range(0, 4));
        put_record(val, 8'($urandom_range(6, 255)));
      end
      default: begin
        fill_payload($urandom_range(0, 4));
        build_record(nxt[15:0], RT_DATA, 8'h00);
        line_q[$urandom_range(1, line_q.size() - 1)] = pick_stray_char(1'b0);
        add_tail();
        send_line();
      end
    endcase
  endtask

  // Once stopped, characters of any value are dropped and each end of stream
  // reports the sticky status again.
  task automatic test_after_stop();
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    repeat (20) send_item(8'($urandom_range(255)), 1'b0);
    send_item(8'($urandom_range(255)), 1'b1);
    repeat (5) send_item(8'($urandom_range(255)), 1'b0);
    send_item(8'hFF, 1'b1);
  endtask

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Every result transaction is matched against the oldest expectation.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("result of kind %0d with no expectation waiting", m_axis_tuser_o);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", want.kind, m_axis_tuser_o);
        check_field("data_byte", want.data_byte, m_axis_tdata_o[7:0]);
        check_field("address", want.address, m_axis_tdata_o[39:8]);
        check_field("status", want.status, m_axis_tdata_o[43:40]);
        check_field("line_number", want.line_number, m_axis_tdata_o[75:44]);
        check_field("start_address", want.start_address, m_axis_tdata_o[107:76]);
        check_field("image_base", want.image_base, m_axis_tdata_o[139:108]);
        check_field("image_length", want.image_length, m_axis_tdata_o[171:140]);
        check_field("last", want.last, m_axis_tlast_o);
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_address_records();
    test_data_records();
    test_random_records();
    test_stream_end();
    test_after_stop();
    s_axis_tvalid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d characters and checked %0d results; stream closed by %s.",
             items_sent, results_seen, end_case.name());
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a stalled handshake.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/ihex_pkg.sv
rtl/core/intel_hex_record_parser.sv
sim/tb_intel_hex_record_parser.sv
